// File: src/sdseq_pkg.sv
// package: codes, field types and constants for the sd card sequencer
package sdseq_pkg;

  localparam int unsigned MaxTransferBytes = 16777215;
  localparam int unsigned QueueDepth = 2;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_RESP  = 2'd1;
  localparam logic [1:0] KIND_XFER  = 2'd2;
  localparam logic [1:0] KIND_WAIT  = 2'd3;

  localparam logic [2:0] OUT_CMD      = 3'd0;
  localparam logic [2:0] OUT_SETTING  = 3'd1;
  localparam logic [2:0] OUT_WAIT     = 3'd2;
  localparam logic [2:0] OUT_BOOTDONE = 3'd3;
  localparam logic [2:0] OUT_XFERDONE = 3'd4;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_INVALID  = 4'd1;
  localparam logic [3:0] ST_POLL     = 4'd2;
  localparam logic [3:0] ST_CMDFAIL  = 4'd3;
  localparam logic [3:0] ST_ECHO     = 4'd4;
  localparam logic [3:0] ST_UNSUPP   = 4'd5;
  localparam logic [3:0] ST_OCRTIME  = 4'd6;
  localparam logic [3:0] ST_ADDRERR  = 4'd7;
  localparam logic [3:0] ST_NOTREADY = 4'd8;

  localparam logic [0:0] REG_OCR_LIMIT  = 1'd0;
  localparam logic [0:0] REG_POLL_LIMIT = 1'd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic        resp_ok;
    logic [31:0] resp_word0;
    logic [31:0] resp_word1;
    logic [31:0] resp_word2;
    logic [31:0] scr_word;
    logic [1:0]  req_op;
    logic [40:0] req_offset;
    logic [23:0] req_length;
    logic [23:0] data_actual;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  out_kind;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [1:0]  data_dir;
    logic [15:0] block_count;
    logic [9:0]  block_bytes;
    logic [1:0]  setting_code;
    logic [3:0]  wait_ms;
    logic [3:0]  status;
    logic [23:0] bytes_done;
    logic [41:0] capacity_bytes;
  } out_word_t;

  // classified item handed from front to back
  typedef struct packed {
    logic        len_bad;  // misaligned, bad opcode or too long
    logic [31:0] block;
    in_word_t    item;
  } cls_word_t;

endpackage

// File: src/sdseq_if.sv
// valid/ready channel interfaces for items and results
interface sdseq_in_if;
  logic                  valid;
  logic                  ready;
  sdseq_pkg::in_word_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sdseq_out_if;
  logic                  valid;
  logic                  ready;
  sdseq_pkg::out_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/sdseq_front.sv
// front: accepts items, checks transfer args, fills a short queue
module sdseq_front #(
  parameter logic [31:0] MaxBytes = sdseq_pkg::MaxTransferBytes
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sdseq_in_if.sink              in_i,
  output logic                  q_valid_o,
  input  logic                  q_pop_i,
  output sdseq_pkg::cls_word_t  q_data_o
);
  localparam int unsigned Depth = sdseq_pkg::QueueDepth;
  localparam int unsigned Aw = $clog2(Depth);

  sdseq_pkg::cls_word_t mem_q [Depth];
  logic [Aw-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [Aw:0]   cnt_q, cnt_d;
  sdseq_pkg::cls_word_t cls;
  logic push;

  always_comb begin
    cls.item  = in_i.data;
    cls.block = in_i.data.req_offset[40:9];
    cls.len_bad = (in_i.data.req_offset[8:0] != 9'd0) || (in_i.data.req_length[8:0] != 9'd0)
                  || in_i.data.req_op[1]
                  || ({8'd0, in_i.data.req_length} > MaxBytes);
  end

  assign in_i.ready = (cnt_q != (Aw+1)'(Depth));
  assign push = in_i.valid && in_i.ready;
  assign q_valid_o = (cnt_q != '0);
  assign q_data_o = mem_q[rd_q];

  always_comb begin
    wr_d = push ? Aw'(wr_q + 1'b1) : wr_q;
    rd_d = q_pop_i ? Aw'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (Aw+1)'(push) - (Aw+1)'(q_pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end
endmodule

// File: src/sdseq_back.sv
// back: sequencer state machine with registered result stage
module sdseq_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [7:0]            cfg_data_i,
  input  logic                  q_valid_i,
  output logic                  q_pop_o,
  input  sdseq_pkg::cls_word_t  q_data_i,
  sdseq_out_if.source           out_o
);
  localparam logic [4:0] PH_IDLE = 5'd0, PH_CMD0 = 5'd1, PH_CMD8 = 5'd2, PH_APP0 = 5'd3,
    PH_OCR0 = 5'd4, PH_APPL = 5'd5, PH_OCR = 5'd6, PH_OCRW = 5'd7, PH_CLK = 5'd8,
    PH_VSW = 5'd9, PH_VOLT = 5'd10, PH_CID = 5'd11, PH_RCA = 5'd12, PH_CSD = 5'd13,
    PH_SEL = 5'd14, PH_APPSCR = 5'd15, PH_SCR = 5'd16, PH_APPBW = 5'd17, PH_BW = 5'd18,
    PH_HOSTBW = 5'd19, PH_READY = 5'd20, PH_STAT = 5'd21, PH_STATW = 5'd22,
    PH_STOP = 5'd23, PH_DATA = 5'd24;

  logic [7:0]  olim_q, plim_q;
  logic [4:0]  phase_q, phase_d;
  logic [7:0]  att_q, att_d;
  logic [15:0] rca_q, rca_d;
  logic [41:0] cap_q, cap_d;
  logic        lv_q, lv_d, pw_q, pw_d;
  logic [31:0] pb_q, pb_d;
  logic [23:0] pl_q, pl_d;
  logic        ov_q;
  sdseq_pkg::out_word_t od_q, res;
  logic        emit;
  sdseq_pkg::in_word_t it;
  logic [7:0]  olim, plim, inc;
  logic [21:0] csize;
  logic [31:0] rarg;

  assign it = q_data_i.item;
  assign q_pop_o = q_valid_i && (!ov_q || out_o.ready);
  assign out_o.valid = ov_q;
  assign out_o.data = od_q;
  assign olim = (olim_q == 8'd0) ? 8'd1 : olim_q;
  assign plim = (plim_q == 8'd0) ? 8'd1 : plim_q;
  assign inc = att_q + 8'd1;
  assign rarg = {rca_q, 16'd0};
  assign csize = {it.resp_word1[5:0], it.resp_word2[31:16]};

  always_comb begin
    phase_d = phase_q; att_d = att_q; rca_d = rca_q; cap_d = cap_q;
    lv_d = lv_q; pw_d = pw_q; pb_d = pb_q; pl_d = pl_q;
    res = '0;
    emit = 1'b0;
    case (it.kind)
      sdseq_pkg::KIND_START: begin
        att_d = '0; rca_d = '0; cap_d = '0; lv_d = 1'b0;
        emit = 1'b1; res.out_kind = sdseq_pkg::OUT_CMD; phase_d = PH_CMD0;
      end
      sdseq_pkg::KIND_XFER: begin
        emit = 1'b1;
        res.out_kind = sdseq_pkg::OUT_XFERDONE;
        if (phase_q != PH_READY) begin
          res.status = sdseq_pkg::ST_NOTREADY;
        end else if (q_data_i.len_bad) begin
          res.status = sdseq_pkg::ST_INVALID;
        end else begin
          pw_d = it.req_op[0]; pb_d = q_data_i.block; pl_d = it.req_length; att_d = '0;
          res.out_kind = sdseq_pkg::OUT_CMD; res.cmd_index = 6'd13; res.cmd_arg = rarg;
          phase_d = PH_STAT;
        end
      end
      sdseq_pkg::KIND_WAIT: begin
        if (phase_q == PH_OCRW) begin
          emit = 1'b1; res.cmd_index = 6'd55; phase_d = PH_APPL;
        end else if (phase_q == PH_STATW) begin
          emit = 1'b1; res.cmd_index = 6'd13; res.cmd_arg = rarg; phase_d = PH_STAT;
        end
      end
      default: begin
        emit = 1'b1;
        res.out_kind = sdseq_pkg::OUT_CMD;
        // default failure path: bring-up done with a failed status
        unique case (phase_q)
          PH_CMD0: if (it.resp_ok) begin
            res.cmd_index = 6'd8; res.cmd_arg = 32'h1aa; phase_d = PH_CMD8;
          end else res.status = sdseq_pkg::ST_CMDFAIL;
          PH_CMD8: if (!it.resp_ok) res.status = sdseq_pkg::ST_CMDFAIL;
            else if (it.resp_word0[11:0] != 12'h1aa) res.status = sdseq_pkg::ST_ECHO;
            else begin res.cmd_index = 6'd55; phase_d = PH_APP0; end
          PH_APP0: if (it.resp_ok) begin res.cmd_index = 6'd41; phase_d = PH_OCR0; end
            else res.status = sdseq_pkg::ST_CMDFAIL;
          PH_OCR0: if (it.resp_ok) begin
            att_d = '0; res.cmd_index = 6'd55; phase_d = PH_APPL;
          end else res.status = sdseq_pkg::ST_CMDFAIL;
          PH_APPL: if (it.resp_ok) begin
            res.cmd_index = 6'd41; res.cmd_arg = 32'h41ff8000; phase_d = PH_OCR;
          end else res.status = sdseq_pkg::ST_CMDFAIL;
          PH_OCR: if (!it.resp_ok) res.status = sdseq_pkg::ST_CMDFAIL;
            else if (it.resp_word0[31]) begin
              if (!it.resp_word0[30]) res.status = sdseq_pkg::ST_UNSUPP;
              else begin
                lv_d = it.resp_word0[24];
                res.out_kind = sdseq_pkg::OUT_SETTING; phase_d = PH_CLK;
              end
            end else begin
              att_d = inc;
              if (inc == 8'd0 || inc >= olim) res.status = sdseq_pkg::ST_OCRTIME;
              else begin
                res.out_kind = sdseq_pkg::OUT_WAIT; res.wait_ms = 4'd5; phase_d = PH_OCRW;
              end
            end
          PH_CLK: if (lv_q) begin res.cmd_index = 6'd11; phase_d = PH_VSW; end
            else begin res.cmd_index = 6'd2; phase_d = PH_CID; end
          PH_VSW: if (it.resp_ok) begin
            res.out_kind = sdseq_pkg::OUT_SETTING; res.setting_code = 2'd1; phase_d = PH_VOLT;
          end else res.status = sdseq_pkg::ST_CMDFAIL;
          PH_VOLT: if (it.resp_ok) begin res.cmd_index = 6'd2; phase_d = PH_CID; end
            else res.status = sdseq_pkg::ST_CMDFAIL;
          PH_CID: if (it.resp_ok) begin res.cmd_index = 6'd3; phase_d = PH_RCA; end
            else res.status = sdseq_pkg::ST_CMDFAIL;
          PH_RCA: if (!it.resp_ok) res.status = sdseq_pkg::ST_CMDFAIL;
            else begin
              rca_d = it.resp_word0[31:16];
              if (it.resp_word0[15:13] != 3'd0) res.status = sdseq_pkg::ST_ADDRERR;
              else if (!it.resp_word0[8]) res.status = sdseq_pkg::ST_NOTREADY;
              else begin
                res.cmd_index = 6'd9; res.cmd_arg = {it.resp_word0[31:16], 16'd0};
                phase_d = PH_CSD;
              end
            end
          PH_CSD: if (!it.resp_ok) res.status = sdseq_pkg::ST_CMDFAIL;
            else if (it.resp_word0[31:30] != 2'd1) res.status = sdseq_pkg::ST_UNSUPP;
            else begin
              cap_d = {({1'b0, csize} + 23'd1), 19'd0};
              res.cmd_index = 6'd7; res.cmd_arg = rarg; phase_d = PH_SEL;
            end
          PH_SEL: if (it.resp_ok) begin
            res.cmd_index = 6'd55; res.cmd_arg = rarg; phase_d = PH_APPSCR;
          end else res.status = sdseq_pkg::ST_CMDFAIL;
          PH_APPSCR: if (it.resp_ok) begin
            res.cmd_index = 6'd51; res.data_dir = 2'd1; res.block_count = 16'd1;
            res.block_bytes = 10'd8; phase_d = PH_SCR;
          end else res.status = sdseq_pkg::ST_CMDFAIL;
          PH_SCR: if (!it.resp_ok) res.status = sdseq_pkg::ST_CMDFAIL;
            else if (it.scr_word[18]) begin
              res.cmd_index = 6'd55; res.cmd_arg = rarg; phase_d = PH_APPBW;
            end else res.status = sdseq_pkg::ST_OK;
          PH_APPBW: if (it.resp_ok) begin
            res.cmd_index = 6'd6; res.cmd_arg = 32'd2; phase_d = PH_BW;
          end else res.status = sdseq_pkg::ST_OK;
          PH_BW: if (it.resp_ok) begin
            res.out_kind = sdseq_pkg::OUT_SETTING; res.setting_code = 2'd2; phase_d = PH_HOSTBW;
          end else res.status = sdseq_pkg::ST_OK;
          PH_HOSTBW: res.status = sdseq_pkg::ST_OK;
          PH_STAT: begin
            res.out_kind = sdseq_pkg::OUT_XFERDONE;
            if (!it.resp_ok) begin
              phase_d = PH_READY; res.status = sdseq_pkg::ST_CMDFAIL;
            end else if (it.resp_word0[12:9] == 4'd4) begin
              res.out_kind = sdseq_pkg::OUT_CMD;
              res.cmd_index = pw_q ? ((pl_q > 24'd512) ? 6'd25 : 6'd24)
                                   : ((pl_q > 24'd512) ? 6'd18 : 6'd17);
              res.cmd_arg = pb_q; res.data_dir = pw_q ? 2'd2 : 2'd1;
              res.block_count = {1'b0, pl_q[23:9]}; res.block_bytes = 10'd512;
              phase_d = PH_DATA;
            end else begin
              att_d = inc;
              if (inc == 8'd0 || inc >= plim) begin
                phase_d = PH_READY; res.status = sdseq_pkg::ST_POLL;
              end else if (it.resp_word0[12:9] == 4'd5) begin
                res.out_kind = sdseq_pkg::OUT_CMD; res.cmd_index = 6'd12; phase_d = PH_STOP;
              end else begin
                res.out_kind = sdseq_pkg::OUT_WAIT; res.wait_ms = 4'd10; phase_d = PH_STATW;
              end
            end
          end
          PH_STOP: begin res.cmd_index = 6'd13; res.cmd_arg = rarg; phase_d = PH_STAT; end
          PH_DATA: begin
            phase_d = PH_READY;
            res.out_kind = sdseq_pkg::OUT_XFERDONE;
            if (!it.resp_ok) res.status = sdseq_pkg::ST_CMDFAIL;
            else if (pw_q || it.data_actual >= pl_q) res.bytes_done = pl_q;
            else res.bytes_done = it.data_actual;
          end
          default: emit = 1'b0;
        endcase
        // fold bring-up failure and success into one place
        if (emit && res.out_kind == sdseq_pkg::OUT_CMD && phase_d == phase_q
            && phase_q != PH_STOP) begin
          res.out_kind = sdseq_pkg::OUT_BOOTDONE;
          if (res.status == sdseq_pkg::ST_OK) begin
            res.capacity_bytes = cap_q; phase_d = PH_READY;
          end else begin
            phase_d = PH_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && emit) begin
      od_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      olim_q <= 8'd10; plim_q <= 8'd10;
      phase_q <= PH_IDLE; att_q <= '0; rca_q <= '0; cap_q <= '0;
      lv_q <= 1'b0; pw_q <= 1'b0; pb_q <= '0; pl_q <= '0; ov_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == sdseq_pkg::REG_OCR_LIMIT) olim_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == sdseq_pkg::REG_POLL_LIMIT) plim_q <= cfg_data_i;
      if (q_pop_o) begin
        phase_q <= phase_d; att_q <= att_d; rca_q <= rca_d; cap_q <= cap_d;
        lv_q <= lv_d; pw_q <= pw_d; pb_q <= pb_d; pl_q <= pl_d;
        ov_q <= emit;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end
endmodule

// File: src/sd_card_init_and_transfer_sequencer_core.sv
// top level: sd card bring-up and transfer command sequencer
// a word accepted at the input is written to the queue, then its result is held in the output register
// throughput: one word per cycle while the output is taken; front check combinational, back state updated per pop
// a two-entry queue parts the front from the back, an output register parts the back
// reset: asynchronous active low, phase idle, limits back to ten, queue and output empty
module sd_card_init_and_transfer_sequencer_core #(
  parameter logic [31:0] MAX_TRANSFER_BYTES = sdseq_pkg::MaxTransferBytes
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [7:0]   cfg_data_i,
  sdseq_in_if.sink     in_i,
  sdseq_out_if.source  out_o
);
  // queue between front and back
  logic                 q_valid, q_pop;
  sdseq_pkg::cls_word_t q_data;

  sdseq_front #(.MaxBytes(MAX_TRANSFER_BYTES)) u_front (
    .clk_i, .rst_ni, .in_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  // back carries out each word against the sequencer phase
  sdseq_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data), .out_o
  );
endmodule

// File: bench/testbench.sv
// testbench: sd card sequencer driven with event words and checked against a predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sdseq_pkg::*;

  // sequencer phases as the predictor tracks them
  typedef enum logic [4:0] {
    PH_IDLE, PH_CMD0, PH_CMD8, PH_APP0, PH_OCR0, PH_APPL, PH_OCR, PH_OCRW,
    PH_CLK, PH_VSW, PH_VOLT, PH_CID, PH_RCA, PH_CSD, PH_SEL, PH_APPSCR,
    PH_SCR, PH_APPBW, PH_BW, PH_HOSTBW, PH_READY, PH_STAT, PH_STATW,
    PH_STOP, PH_DATA
  } seq_phase_e;

  localparam int unsigned BlockBytes = 512;
  localparam int unsigned DrainCycles = 24;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [0:0] cfg_idx_i = '0;
  logic [7:0] cfg_data_i = '0;

  sdseq_in_if  in_ch ();
  sdseq_out_if out_ch ();

  sd_card_init_and_transfer_sequencer_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always #10 clk_i = ~clk_i;

  // predictor copy of the block state and its limits
  seq_phase_e  ph;
  logic [7:0]  attempt_cnt;
  logic [15:0] card_addr;
  logic [41:0] card_cap;
  logic        low_volt;
  logic        pend_write;
  logic [31:0] pend_block;
  logic [23:0] pend_len;
  logic [7:0]  ocr_limit;
  logic [7:0]  poll_limit;

  in_word_t  send_words[$];
  out_word_t expected_actions[$];
  int        errors = 0;
  bit        quiet = 1'b0;

  function automatic out_word_t go_cmd(logic [5:0] idx, logic [31:0] arg, seq_phase_e nx);
    out_word_t a;
    a = '0;
    a.out_kind = OUT_CMD;
    a.cmd_index = idx;
    a.cmd_arg = arg;
    ph = nx;
    return a;
  endfunction

  function automatic out_word_t go_setting(logic [1:0] code, seq_phase_e nx);
    out_word_t a;
    a = '0;
    a.out_kind = OUT_SETTING;
    a.setting_code = code;
    ph = nx;
    return a;
  endfunction

  function automatic out_word_t go_wait(logic [3:0] ms, seq_phase_e nx);
    out_word_t a;
    a = '0;
    a.out_kind = OUT_WAIT;
    a.wait_ms = ms;
    ph = nx;
    return a;
  endfunction

  // bring-up finished: ready on success, back to idle otherwise
  function automatic out_word_t boot_end(logic [3:0] st);
    out_word_t a;
    a = '0;
    a.out_kind = OUT_BOOTDONE;
    a.status = st;
    if (st == ST_OK) begin
      a.capacity_bytes = card_cap;
      ph = PH_READY;
    end else begin
      ph = PH_IDLE;
    end
    return a;
  endfunction

  function automatic out_word_t xfer_end(logic [3:0] st, logic [23:0] bytes);
    out_word_t a;
    a = '0;
    a.out_kind = OUT_XFERDONE;
    a.status = st;
    a.bytes_done = bytes;
    return a;
  endfunction

  function automatic logic [31:0] rca_arg();
    return {card_addr, 16'h0};
  endfunction

  // next action of the sequencer for one event word; 0 when the word is ignored
  function automatic bit sequence_step(input in_word_t w, output out_word_t a);
    logic [7:0]  olim;
    logic [7:0]  plim;
    logic [3:0]  cs;
    logic [21:0] csize;
    logic [5:0]  idx;
    bit          multi;
    bit          has;
    has = 1'b1;
    a = '0;
    olim = (ocr_limit == 0) ? 8'd1 : ocr_limit;
    plim = (poll_limit == 0) ? 8'd1 : poll_limit;
    case (w.kind)
      KIND_START: begin
        attempt_cnt = '0;
        card_addr = '0;
        card_cap = '0;
        low_volt = 1'b0;
        a = go_cmd(6'd0, 32'd0, PH_CMD0);
      end
      KIND_XFER: begin
        if (ph != PH_READY) begin
          a = xfer_end(ST_NOTREADY, '0);
        end else if (w.req_offset[8:0] != 0 || w.req_length[8:0] != 0 || w.req_op > 2'd1 ||
                     w.req_length > MaxTransferBytes) begin
          a = xfer_end(ST_INVALID, '0);
        end else begin
          pend_write = w.req_op[0];
          pend_block = w.req_offset[40:9];
          pend_len = w.req_length;
          attempt_cnt = '0;
          a = go_cmd(6'd13, rca_arg(), PH_STAT);
        end
      end
      KIND_WAIT: begin
        if (ph == PH_OCRW) a = go_cmd(6'd55, 32'd0, PH_APPL);
        else if (ph == PH_STATW) a = go_cmd(6'd13, rca_arg(), PH_STAT);
        else has = 1'b0;
      end
      default: begin
        case (ph)
          PH_CMD0: a = w.resp_ok ? go_cmd(6'd8, 32'h1aa, PH_CMD8) : boot_end(ST_CMDFAIL);
          PH_CMD8: begin
            if (!w.resp_ok) a = boot_end(ST_CMDFAIL);
            else if (w.resp_word0[11:0] != 12'h1aa) a = boot_end(ST_ECHO);
            else a = go_cmd(6'd55, 32'd0, PH_APP0);
          end
          PH_APP0: a = w.resp_ok ? go_cmd(6'd41, 32'd0, PH_OCR0) : boot_end(ST_CMDFAIL);
          PH_OCR0: begin
            if (!w.resp_ok) a = boot_end(ST_CMDFAIL);
            else begin
              attempt_cnt = '0;
              a = go_cmd(6'd55, 32'd0, PH_APPL);
            end
          end
          PH_APPL: a = w.resp_ok ? go_cmd(6'd41, 32'h41ff8000, PH_OCR) : boot_end(ST_CMDFAIL);
          PH_OCR: begin
            if (!w.resp_ok) a = boot_end(ST_CMDFAIL);
            else if (w.resp_word0[31]) begin
              // ready card must report high capacity
              if (!w.resp_word0[30]) a = boot_end(ST_UNSUPP);
              else begin
                low_volt = w.resp_word0[24];
                a = go_setting(2'd0, PH_CLK);
              end
            end else begin
              attempt_cnt = attempt_cnt + 8'd1;
              if (attempt_cnt == 0 || attempt_cnt >= olim) a = boot_end(ST_OCRTIME);
              else a = go_wait(4'd5, PH_OCRW);
            end
          end
          // a failed clock setting is not fatal
          PH_CLK: a = low_volt ? go_cmd(6'd11, 32'd0, PH_VSW) : go_cmd(6'd2, 32'd0, PH_CID);
          PH_VSW: a = w.resp_ok ? go_setting(2'd1, PH_VOLT) : boot_end(ST_CMDFAIL);
          PH_VOLT: a = w.resp_ok ? go_cmd(6'd2, 32'd0, PH_CID) : boot_end(ST_CMDFAIL);
          PH_CID: a = w.resp_ok ? go_cmd(6'd3, 32'd0, PH_RCA) : boot_end(ST_CMDFAIL);
          PH_RCA: begin
            if (!w.resp_ok) a = boot_end(ST_CMDFAIL);
            else begin
              card_addr = w.resp_word0[31:16];
              if (w.resp_word0[15:13] != 0) a = boot_end(ST_ADDRERR);
              else if (!w.resp_word0[8]) a = boot_end(ST_NOTREADY);
              else a = go_cmd(6'd9, rca_arg(), PH_CSD);
            end
          end
          PH_CSD: begin
            if (!w.resp_ok) a = boot_end(ST_CMDFAIL);
            else if (w.resp_word0[31:30] != 2'd1) a = boot_end(ST_UNSUPP);
            else begin
              csize = {w.resp_word1[5:0], w.resp_word2[31:16]};
              card_cap = ({20'd0, csize} + 42'd1) << 19;
              a = go_cmd(6'd7, rca_arg(), PH_SEL);
            end
          end
          PH_SEL: a = w.resp_ok ? go_cmd(6'd55, rca_arg(), PH_APPSCR) : boot_end(ST_CMDFAIL);
          PH_APPSCR: begin
            if (!w.resp_ok) a = boot_end(ST_CMDFAIL);
            else begin
              a = go_cmd(6'd51, 32'd0, PH_SCR);
              a.data_dir = 2'd1;
              a.block_count = 16'd1;
              a.block_bytes = 10'd8;
            end
          end
          PH_SCR: begin
            if (!w.resp_ok) a = boot_end(ST_CMDFAIL);
            else if (w.scr_word[18]) a = go_cmd(6'd55, rca_arg(), PH_APPBW);
            else a = boot_end(ST_OK);
          end
          // bus width steps never fail bring-up
          PH_APPBW: a = w.resp_ok ? go_cmd(6'd6, 32'd2, PH_BW) : boot_end(ST_OK);
          PH_BW: a = w.resp_ok ? go_setting(2'd2, PH_HOSTBW) : boot_end(ST_OK);
          PH_HOSTBW: a = boot_end(ST_OK);
          PH_STAT: begin
            cs = w.resp_word0[12:9];
            if (!w.resp_ok) begin
              ph = PH_READY;
              a = xfer_end(ST_CMDFAIL, '0);
            end else if (cs == 4'd4) begin
              multi = pend_len > BlockBytes;
              if (pend_write) idx = multi ? 6'd25 : 6'd24;
              else idx = multi ? 6'd18 : 6'd17;
              a = go_cmd(idx, pend_block, PH_DATA);
              a.data_dir = pend_write ? 2'd2 : 2'd1;
              a.block_count = {1'b0, pend_len[23:9]};
              a.block_bytes = 10'd512;
            end else begin
              attempt_cnt = attempt_cnt + 8'd1;
              if (attempt_cnt == 0 || attempt_cnt >= plim) begin
                ph = PH_READY;
                a = xfer_end(ST_POLL, '0);
              end else if (cs == 4'd5) begin
                a = go_cmd(6'd12, 32'd0, PH_STOP);
              end else begin
                a = go_wait(4'd10, PH_STATW);
              end
            end
          end
          // stop command answer is not checked
          PH_STOP: a = go_cmd(6'd13, rca_arg(), PH_STAT);
          PH_DATA: begin
            ph = PH_READY;
            if (!w.resp_ok) a = xfer_end(ST_CMDFAIL, '0);
            else if (pend_write) a = xfer_end(ST_OK, pend_len);
            else a = xfer_end(ST_OK, (w.data_actual < pend_len) ? w.data_actual : pend_len);
          end
          default: has = 1'b0;
        endcase
      end
    endcase
    return has;
  endfunction

  // random word shaped to what the current phase waits for, with some noise
  function automatic in_word_t shape_word(seq_phase_e p);
    in_word_t w;
    logic [3:0] cs;
    w.kind = KIND_RESP;
    w.resp_ok = ($urandom_range(0, 19) != 0);
    w.resp_word0 = $urandom;
    w.resp_word1 = $urandom;
    w.resp_word2 = $urandom;
    w.scr_word = $urandom;
    w.req_op = 2'($urandom_range(0, 3));
    w.req_offset = 41'({$urandom, $urandom});
    w.req_length = 24'($urandom);
    w.data_actual = 24'($urandom);
    if ($urandom_range(0, 11) == 0) return w;
    if ($urandom_range(0, 79) == 0) begin
      w.kind = KIND_START;
      return w;
    end
    case (p)
      PH_IDLE: w.kind = KIND_START;
      PH_OCRW, PH_STATW: w.kind = KIND_WAIT;
      PH_CMD8: if ($urandom_range(0, 9) != 0) w.resp_word0[11:0] = 12'h1aa;
      PH_OCR: begin
        w.resp_word0[31] = ($urandom_range(0, 2) == 0);
        w.resp_word0[30] = ($urandom_range(0, 7) != 0);
      end
      PH_RCA: begin
        if ($urandom_range(0, 9) != 0) w.resp_word0[15:13] = '0;
        w.resp_word0[8] = ($urandom_range(0, 9) != 0);
      end
      PH_CSD: if ($urandom_range(0, 9) != 0) w.resp_word0[31:30] = 2'd1;
      PH_READY: begin
        w.kind = KIND_XFER;
        if ($urandom_range(0, 9) != 0) begin
          w.req_op = 2'($urandom_range(0, 1));
          w.req_offset[8:0] = '0;
          if ($urandom_range(0, 15) != 0) w.req_length = 24'($urandom_range(0, 6) * BlockBytes);
          else w.req_length = 24'($urandom_range(0, 32767) * BlockBytes);
        end
      end
      PH_STAT: begin
        cs = 4'($urandom_range(0, 3));
        if (cs < 2) w.resp_word0[12:9] = 4'd4;
        else if (cs == 2) w.resp_word0[12:9] = 4'd5;
      end
      default: ;
    endcase
    return w;
  endfunction

  // driver: presents queued words, updates the prediction at each accepted word
  int unsigned send_gap = 0;
  int unsigned auto_goal = 0;
  int unsigned auto_done = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t a;
    bit fire;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else begin
      fire = in_ch.valid && in_ch.ready;
      if (fire) begin
        if (sequence_step(in_ch.data, a)) expected_actions.push_back(a);
        void'(send_words.pop_front());
        if (!quiet && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 14);
      end
      // random words are shaped from the phase the last accepted word left
      if (send_words.size() == 0 && auto_done < auto_goal) begin
        send_words.push_back(shape_word(ph));
        auto_done++;
      end
      if (!in_ch.valid || fire) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (send_words.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.data <= send_words[0];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random ready stalls, each accepted action checked against the oldest expectation
  int unsigned stall_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t e;
    out_word_t g;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        g = out_ch.data;
        if (expected_actions.size() == 0) begin
          $error("unexpected word: out_kind %0d", g.out_kind);
          errors++;
        end else begin
          e = expected_actions.pop_front();
          if (g.out_kind !== e.out_kind) begin
            $error("out_kind exp %0d got %0d", e.out_kind, g.out_kind); errors++;
          end
          if (g.cmd_index !== e.cmd_index) begin
            $error("cmd_index exp %0d got %0d", e.cmd_index, g.cmd_index); errors++;
          end
          if (g.cmd_arg !== e.cmd_arg) begin
            $error("cmd_arg exp %h got %h", e.cmd_arg, g.cmd_arg); errors++;
          end
          if (g.data_dir !== e.data_dir) begin
            $error("data_dir exp %0d got %0d", e.data_dir, g.data_dir); errors++;
          end
          if (g.block_count !== e.block_count) begin
            $error("block_count exp %0d got %0d", e.block_count, g.block_count); errors++;
          end
          if (g.block_bytes !== e.block_bytes) begin
            $error("block_bytes exp %0d got %0d", e.block_bytes, g.block_bytes); errors++;
          end
          if (g.setting_code !== e.setting_code) begin
            $error("setting_code exp %0d got %0d", e.setting_code, g.setting_code); errors++;
          end
          if (g.wait_ms !== e.wait_ms) begin
            $error("wait_ms exp %0d got %0d", e.wait_ms, g.wait_ms); errors++;
          end
          if (g.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, g.status); errors++;
          end
          if (g.bytes_done !== e.bytes_done) begin
            $error("bytes_done exp %0d got %0d", e.bytes_done, g.bytes_done); errors++;
          end
          if (g.capacity_bytes !== e.capacity_bytes) begin
            $error("capacity_bytes exp %h got %h", e.capacity_bytes, g.capacity_bytes); errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 14);
      end
    end
  end

  // hand one word to the driver and wait until it is taken
  task automatic send_one(in_word_t w);
    send_words.push_back(w);
    do @(negedge clk_i); while (send_words.size() != 0);
  endtask

  task automatic drain();
    while (send_words.size() != 0 || expected_actions.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_limits(logic [7:0] ocr_lim, logic [7:0] poll_lim);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_OCR_LIMIT;
    cfg_data_i <= ocr_lim;
    @(posedge clk_i);
    cfg_idx_i <= REG_POLL_LIMIT;
    cfg_data_i <= poll_lim;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ocr_limit = ocr_lim;
    poll_limit = poll_lim;
  endtask

  // the driver shapes each random word itself so words can follow back to back
  task automatic run_random(int unsigned n);
    auto_goal = auto_goal + n;
    while (auto_done != auto_goal || send_words.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    in_word_t w;
    ph = PH_IDLE;
    attempt_cnt = '0;
    card_addr = '0;
    card_cap = '0;
    low_volt = 1'b0;
    pend_write = 1'b0;
    pend_block = '0;
    pend_len = '0;
    ocr_limit = 8'd10;
    poll_limit = 8'd10;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // directed: requests and stray events before bring-up, then a clean bring-up
    w = '1;
    w.kind = KIND_XFER;
    send_one(w);
    w.kind = KIND_RESP;
    send_one(w);
    w.kind = KIND_WAIT;
    send_one(w);
    w = '0;
    w.kind = KIND_START;
    send_one(w);
    while (ph != PH_READY && ph != PH_IDLE) begin
      w = '0;
      w.kind = (ph == PH_OCRW) ? KIND_WAIT : KIND_RESP;
      w.resp_ok = 1'b1;
      w.resp_word0 = {8'hc1, 8'hff, 3'b000, 4'd4, 1'b1, 8'haa};
      w.resp_word0[11:0] = 12'h1aa;
      if (ph == PH_CSD) w.resp_word0[31:30] = 2'd1;
      if (ph == PH_RCA) w.resp_word0 = 32'hffff_0100;
      w.resp_word1 = '1;
      w.resp_word2 = '1;
      w.scr_word = '1;
      send_one(w);
    end
    // directed transfers: zero length, bad opcode, misaligned, full width length, top block offset
    w = '0;
    w.kind = KIND_XFER;
    send_one(w);
    w.kind = KIND_RESP;
    w.resp_ok = 1'b1;
    w.resp_word0[12:9] = 4'd4;
    send_one(w);
    send_one(w);
    w.kind = KIND_XFER;
    w.req_op = 2'd3;
    send_one(w);
    w.req_op = 2'd1;
    w.req_offset = 41'h1;
    send_one(w);
    w.req_offset = '0;
    w.req_length = '1;
    send_one(w);
    w.req_length = 24'd1024;
    w.req_offset = {32'hffffffff, 9'd0};
    send_one(w);
    drain();

    run_random(200);
    drain();
    write_limits(8'd1, 8'd1);
    run_random(150);
    drain();
    write_limits(8'd255, 8'd255);
    run_random(200);
    drain();
    write_limits(8'd0, 8'd0);
    run_random(120);
    drain();
    write_limits(8'd3, 8'd2);
    run_random(120);
    quiet = 1'b1;
    run_random(100);
    drain();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
